>>> rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg: shared types and constants for the 3x3 LBP pixel stream block
// Field widths, register indexes, reset values and the record types that
// pass between the scan counters, the line buffer and the window stage.
// ----------------------------------------------------------------------------
package lbp_pkg;

	// Default depth of each line store
	localparam int MAX_WIDTH_DEF = 1024;

	// Field and register widths
	localparam int PIXEL_W        = 8;
	localparam int IMAGE_WIDTH_W  = 11;
	localparam int IMAGE_HEIGHT_W = 12;
	localparam int CFG_DATA_W     = 12;
	localparam int ROW_W          = 12;

	// Configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// Register reset values
	localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = IMAGE_WIDTH_W'(102);
	localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = IMAGE_HEIGHT_W'(102);

	// Smallest frame side the block works on
	localparam int MIN_SIDE = 3;

	// Raster position flags of one pixel
	typedef struct packed {
		logic emit;      // window center is an interior pixel
		logic row_end;   // last pixel of the input row
		logic frame_end; // last pixel of the input frame
	} pos_t;

	// One line buffer entry: row r-2 and row r-1 at the same column
	typedef struct packed {
		logic [PIXEL_W-1:0] upper;
		logic [PIXEL_W-1:0] lower;
	} line_pair_t;

endpackage

>>> rtl/lbp_scan.sv
// ----------------------------------------------------------------------------
// lbp_scan: raster position counters and configuration registers
// Holds image width and height, tracks column and row of the next pixel,
// and tracks how far the line buffer has been written since reset.
// ----------------------------------------------------------------------------
module lbp_scan #(
	parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 step,
	output logic [$clog2(MAX_WIDTH)-1:0]         col,
	output lbp_pkg::pos_t                        pos,
	output logic                                 hit
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int EWA = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (EWA > lbp_pkg::IMAGE_WIDTH_W) ? EWA : lbp_pkg::IMAGE_WIDTH_W;
	localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
	localparam logic [EW-1:0] MINW = EW'(lbp_pkg::MIN_SIDE);
	localparam logic [lbp_pkg::ROW_W-1:0] MINH = lbp_pkg::ROW_W'(lbp_pkg::MIN_SIDE);

	logic [lbp_pkg::IMAGE_WIDTH_W-1:0]  width_q;
	logic [lbp_pkg::IMAGE_HEIGHT_W-1:0] height_q;
	logic [CW-1:0]                      col_q;
	logic [lbp_pkg::ROW_W-1:0]          row_q;
	logic [CW:0]                        fill_q;

	logic [EW-1:0]                      w_cfg;
	logic [EW-1:0]                      w_eff;
	logic [EW-1:0]                      w_last;
	logic [lbp_pkg::ROW_W-1:0]          h_eff;
	logic [lbp_pkg::ROW_W-1:0]          h_last;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lbp_pkg::IMAGE_WIDTH_RST;
			height_q <= lbp_pkg::IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbp_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[lbp_pkg::IMAGE_WIDTH_W-1:0];
				end
				lbp_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[lbp_pkg::IMAGE_HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the frame size to the supported range
	always_comb begin
		w_cfg = EW'(width_q);
		if (w_cfg < MINW) begin
			w_eff = MINW;
		end else if (w_cfg > MAXW) begin
			w_eff = MAXW;
		end else begin
			w_eff = w_cfg;
		end
		w_last = w_eff - EW'(1);
		h_eff  = (height_q < MINH) ? MINH : height_q;
		h_last = h_eff - lbp_pkg::ROW_W'(1);
	end

	// Position flags of the pixel at the current counters
	always_comb begin
		pos.row_end   = (EW'(col_q) >= w_last);
		pos.frame_end = pos.row_end && (row_q >= h_last);
		pos.emit      = (row_q >= lbp_pkg::ROW_W'(2)) && (col_q >= CW'(2));
	end

	assign col = col_q;
	assign hit = ({1'b0, col_q} < fill_q);

	// Advance the counters and the written extent on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
		end else if (step) begin
			if (!hit) begin
				fill_q <= {1'b0, col_q} + (CW + 1)'(1);
			end
			if (pos.row_end) begin
				col_q <= '0;
				row_q <= pos.frame_end ? '0 : row_q + lbp_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

>>> rtl/lbp_line_buf.sv
// ----------------------------------------------------------------------------
// lbp_line_buf: two line stores in one memory
// Each entry holds rows r-2 and r-1 at one column. One write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module lbp_line_buf #(
	parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output lbp_pkg::line_pair_t          rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  lbp_pkg::line_pair_t          wr_data
);

	lbp_pkg::line_pair_t mem [MAX_WIDTH];
	lbp_pkg::line_pair_t rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/lbp_window.sv
// ----------------------------------------------------------------------------
// lbp_window: 3x3 window, pattern compare and result register
// Shifts the window by one column per pixel, compares the eight neighbors
// with the center and holds the code until the output side takes it.
// ----------------------------------------------------------------------------
module lbp_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [lbp_pkg::PIXEL_W-1:0]   pixel_s1,
	input  logic [lbp_pkg::PIXEL_W-1:0]   up_s1,
	input  logic [lbp_pkg::PIXEL_W-1:0]   mid_s1,
	input  lbp_pkg::pos_t                 pos_s1,
	input  logic                          take,
	output logic                          code_valid,
	output logic [lbp_pkg::PIXEL_W-1:0]   lbp_code,
	output logic                          last_in_row,
	output logic                          last_in_frame
);

	// [0..2]: column c-2 top, mid, bottom; [3..5]: column c-1
	logic [lbp_pkg::PIXEL_W-1:0] win_q [6];
	logic [lbp_pkg::PIXEL_W-1:0] ctr;
	logic [lbp_pkg::PIXEL_W-1:0] code;

	logic                        valid_s2;
	logic [lbp_pkg::PIXEL_W-1:0] code_s2;
	logic                        row_end_s2;
	logic                        frame_end_s2;

	// Neighbor greater than center, top-left clockwise to left
	always_comb begin
		ctr     = win_q[4];
		code[7] = win_q[0] > ctr;
		code[6] = win_q[3] > ctr;
		code[5] = up_s1    > ctr;
		code[4] = mid_s1   > ctr;
		code[3] = pixel_s1 > ctr;
		code[2] = win_q[5] > ctr;
		code[1] = win_q[2] > ctr;
		code[0] = win_q[1] > ctr;
	end

	// Shift the window one column
	always_ff @(posedge clk) begin
		if (adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= pixel_s1;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= pos_s1.emit;
		end else if (take) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			code_s2      <= code;
			row_end_s2   <= pos_s1.row_end;
			frame_end_s2 <= pos_s1.frame_end;
		end
	end

	assign code_valid    = valid_s2;
	assign lbp_code      = code_s2;
	assign last_in_row   = row_end_s2;
	assign last_in_frame = frame_end_s2;

endmodule

>>> rtl/lbp_3x3_pixel_stream_top.sv
// ----------------------------------------------------------------------------
// lbp_3x3_pixel_stream_top: 3x3 local binary pattern over a pixel stream
// Raster pixels in, one 8-bit LBP code per interior pixel out.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock as long as the output side keeps up,
// and the code of a completed window is registered out of stage 1. The
// pace is set by the single read port of the line buffer, read once per
// pixel, and by a one-entry result register, so pixel_stall rises only while
// a code waits in the result register and code_stall is high. Pixels of rows
// 0 and 1 and columns 0 and 1 produce no code. Line buffer entries never
// written since reset read as zero through a written-extent counter, so no
// clearing pass follows reset. Write image_width and image_height only while
// no transaction is in flight.
module lbp_3x3_pixel_stream_top #(
	parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               pixel_valid,
	output logic                               pixel_stall,
	input  logic [lbp_pkg::PIXEL_W-1:0]        pixel,
	output logic                               code_valid,
	input  logic                               code_stall,
	output logic [lbp_pkg::PIXEL_W-1:0]        lbp_code,
	output logic                               last_in_row,
	output logic                               last_in_frame
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic                          accept;
	logic                          advance;
	logic                          s2_free;
	logic                          take;

	logic [CW-1:0]                 col;
	lbp_pkg::pos_t                 pos;
	logic                          hit;

	logic                          valid_s1;
	logic [lbp_pkg::PIXEL_W-1:0]   pixel_s1;
	logic [CW-1:0]                 idx_s1;
	lbp_pkg::pos_t                 pos_s1;
	logic                          hit_s1;

	lbp_pkg::line_pair_t           rd_pair;
	lbp_pkg::line_pair_t           wr_pair;
	logic [lbp_pkg::PIXEL_W-1:0]   up_s1;
	logic [lbp_pkg::PIXEL_W-1:0]   mid_s1;

	// Handshake control
	assign take        = code_valid && !code_stall;
	assign s2_free     = !code_valid || !code_stall;
	assign advance     = valid_s1 && s2_free;
	assign pixel_stall = valid_s1 && !s2_free;
	assign accept      = pixel_valid && !pixel_stall;

	lbp_scan #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.col       (col),
		.pos       (pos),
		.hit       (hit)
	);

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload, loaded with the line buffer read
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			idx_s1   <= col;
			pos_s1   <= pos;
			hit_s1   <= hit;
		end
	end

	// Unwritten columns read as zero
	assign up_s1  = hit_s1 ? rd_pair.upper : '0;
	assign mid_s1 = hit_s1 ? rd_pair.lower : '0;

	// Move rows down one line at the current column
	assign wr_pair.upper = mid_s1;
	assign wr_pair.lower = pixel_s1;

	lbp_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (rd_pair),
		.wr_en   (advance),
		.wr_addr (idx_s1),
		.wr_data (wr_pair)
	);

	lbp_window u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (advance),
		.pixel_s1      (pixel_s1),
		.up_s1         (up_s1),
		.mid_s1        (mid_s1),
		.pos_s1        (pos_s1),
		.take          (take),
		.code_valid    (code_valid),
		.lbp_code      (lbp_code),
		.last_in_row   (last_in_row),
		.last_in_frame (last_in_frame)
	);

endmodule

>>> rtl/lbp_checker.sv
// ----------------------------------------------------------------------------
// lbp_checker: port-level checks for the LBP pixel stream block
// Watches the top level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module lbp_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pixel_valid,
	input  logic                             pixel_stall,
	input  logic                             code_valid,
	input  logic                             code_stall,
	input  logic [lbp_pkg::PIXEL_W-1:0]      lbp_code,
	input  logic                             last_in_row,
	input  logic                             last_in_frame
);

	// Hold a stalled result transaction
	a_code_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> code_valid && $stable(lbp_code)
			&& $stable(last_in_row) && $stable(last_in_frame))
		else $error("stalled code transaction changed");

	// Stall input only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> code_valid && code_stall)
		else $error("pixel stall without a blocked result");

	// Frame end always closes a row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && last_in_frame |-> last_in_row)
		else $error("frame end without row end");

	// A fresh code follows an earlier pixel transaction
	a_code_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(code_valid) |-> $past(pixel_valid && !pixel_stall, 2))
		else $error("code without a preceding pixel transaction");

endmodule

bind lbp_3x3_pixel_stream_top lbp_checker u_lbp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pixel_valid   (pixel_valid),
	.pixel_stall   (pixel_stall),
	.code_valid    (code_valid),
	.code_stall    (code_stall),
	.lbp_code      (lbp_code),
	.last_in_row   (last_in_row),
	.last_in_frame (last_in_frame)
);

>>> dv/lbp_3x3_pixel_stream_top_tb.sv
// ----------------------------------------------------------------------------
// lbp_3x3_pixel_stream_top_tb: self-checking bench for the 3x3 LBP stream
// Streams raster pixels through the block under several frame sizes and
// handshake pressures. Every accepted pixel runs through a local model of the
// line stores and window, and each code transaction is checked field by
// field against the oldest predicted code.
// ----------------------------------------------------------------------------

class lbp_code_scoreboard;

	localparam int unsigned DEPTH = lbp_pkg::MAX_WIDTH_DEF;

	typedef struct packed {
		logic [7:0] code;
		logic       row_last;
		logic       frame_last;
	} code_rec_t;

	// Model state: two previous rows, last two window columns, scan counters
	logic [7:0]  upper_row [DEPTH];
	logic [7:0]  lower_row [DEPTH];
	logic [7:0]  win [6];
	int unsigned col;
	int unsigned row;
	logic [10:0] width_reg;
	logic [11:0] height_reg;

	code_rec_t   codes_due [$];
	int          errors;
	int          pixels_seen;
	int          codes_seen;
	int          frames_seen;

	function new();
		foreach (upper_row[i]) begin
			upper_row[i] = '0;
			lower_row[i] = '0;
		end
		foreach (win[i]) win[i] = '0;
		col         = 0;
		row         = 0;
		width_reg   = lbp_pkg::IMAGE_WIDTH_RST;
		height_reg  = lbp_pkg::IMAGE_HEIGHT_RST;
		errors      = 0;
		pixels_seen = 0;
		codes_seen  = 0;
		frames_seen = 0;
	endfunction

	function int pending();
		return codes_due.size();
	endfunction

	function void write_reg(input logic idx, input logic [11:0] data);
		if (idx == lbp_pkg::REG_IMAGE_WIDTH)
			width_reg = data[10:0];
		else
			height_reg = data;
	endfunction

	// Advance the model by one accepted pixel; queue a code for interior centers
	function void take_pixel(input logic [7:0] px);
		int unsigned w, h, c, r, slot;
		logic [7:0]  up, mid, ctr;
		logic        row_end, frame_end;
		code_rec_t   rec;
		w = (width_reg < 3) ? 3 : ((width_reg > DEPTH) ? DEPTH : width_reg);
		h = (height_reg < 3) ? 3 : height_reg;
		c = col;
		r = row;
		slot = (c < DEPTH) ? c : DEPTH - 1;
		up = upper_row[slot];
		mid = lower_row[slot];
		row_end = (c >= w - 1);
		frame_end = row_end && (r >= h - 1);
		pixels_seen++;

		if (r >= 2 && c >= 2) begin
			ctr = win[4];
			rec.code = {win[0] > ctr, win[3] > ctr, up > ctr, mid > ctr,
				px > ctr, win[5] > ctr, win[2] > ctr, win[1] > ctr};
			rec.row_last = row_end;
			rec.frame_last = frame_end;
			codes_due.push_back(rec);
		end

		// Shift the window one column and refresh the line stores
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = up;
		win[4] = mid;
		win[5] = px;
		upper_row[slot] = mid;
		lower_row[slot] = px;

		if (row_end) begin
			col = 0;
			row = frame_end ? 0 : ((r + 1) & 12'hFFF);
		end else begin
			col = c + 1;
		end
	endfunction

	task report(input string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Compare one code transaction with the oldest prediction
	task check_code(input logic [7:0] code, input logic row_last, input logic frame_last);
		code_rec_t exp_rec;
		if (codes_due.size() == 0) begin
			report($sformatf("code %02h with no code pending", code));
		end else begin
			exp_rec = codes_due.pop_front();
			codes_seen++;
			if (code !== exp_rec.code)
				report($sformatf("lbp_code %02h, predicted %02h", code, exp_rec.code));
			if (row_last !== exp_rec.row_last)
				report($sformatf("last_in_row %b, predicted %b", row_last,
					exp_rec.row_last));
			if (frame_last !== exp_rec.frame_last)
				report($sformatf("last_in_frame %b, predicted %b", frame_last,
					exp_rec.frame_last));
			if (exp_rec.frame_last)
				frames_seen++;
		end
	endtask

endclass

module lbp_3x3_pixel_stream_top_tb;

	localparam int CLK_PERIOD     = 8;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 350;
	localparam int TIMEOUT_CYCLES = 400000;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           cfg_we      = 1'b0;
	logic                           cfg_index   = 1'b0;
	logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
	logic                           pixel_valid = 1'b0;
	logic                           pixel_stall;
	logic [lbp_pkg::PIXEL_W-1:0]    pixel       = '0;
	logic                           code_valid;
	logic                           code_stall  = 1'b0;
	logic [lbp_pkg::PIXEL_W-1:0]    lbp_code;
	logic                           last_in_row;
	logic                           last_in_frame;

	int idle_pct  = 0;
	int stall_pct = 0;
	int cfg_count = 0;

	lbp_code_scoreboard sb;

	lbp_3x3_pixel_stream_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel_valid   (pixel_valid),
		.pixel_stall   (pixel_stall),
		.pixel         (pixel),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.lbp_code      (lbp_code),
		.last_in_row   (last_in_row),
		.last_in_frame (last_in_frame)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stall the code side at random
	always @(posedge clk) begin
		code_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watch both channels: predict on each pixel transaction, check each code
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall)
				sb.take_pixel(pixel);
			if (code_valid && !code_stall)
				sb.check_code(lbp_code, last_in_row, last_in_frame);
		end
	end

	// Offer one pixel, with an optional gap first; return once it is taken
	task automatic send_pixel(input logic [7:0] px);
		if ($urandom_range(99) < idle_pct) begin
			pixel_valid <= 1'b0;
			pixel <= 8'($urandom);
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
	endtask

	// Drain the block, then write both frame registers back to back
	task automatic configure(input logic [11:0] wdata, input logic [11:0] hdata);
		pixel_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= lbp_pkg::REG_IMAGE_WIDTH;
		cfg_data <= wdata;
		@(posedge clk);
		sb.write_reg(lbp_pkg::REG_IMAGE_WIDTH, wdata);
		cfg_index <= lbp_pkg::REG_IMAGE_HEIGHT;
		cfg_data <= hdata;
		@(posedge clk);
		sb.write_reg(lbp_pkg::REG_IMAGE_HEIGHT, hdata);
		cfg_we <= 1'b0;
		cfg_count++;
	endtask

	initial begin
		int          phase;
		int          random_px;
		int          count;
		int          pos;
		int unsigned ew, eh;
		logic [11:0] wdata, hdata;
		logic [7:0]  px;

		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: three 3x3 frames - all neighbors above, all equal, alternating
		configure(12'd3, 12'd3);
		for (int i = 0; i < 27; i++) begin
			pos = i % 9;
			case (i / 9)
				0: px = (pos == 4) ? 8'd0 : 8'd255;
				1: px = 8'd128;
				default: begin
					if (pos == 4)
						px = 8'd100;
					else if (pos == 0 || pos == 2 || pos == 6 || pos == 8)
						px = 8'd101;
					else
						px = 8'd99;
				end
			endcase
			send_pixel(px);
		end

		// Directed: two narrow rows, then widen to the clipped maximum for row 2
		configure(12'd3, 12'hFFF);
		for (int i = 0; i < 6; i++)
			send_pixel(8'($urandom));
		configure(12'h7FF, 12'hFFF);
		for (int i = 0; i < 1024; i++)
			send_pixel(8'($urandom));

		// Random phases, cycling through the handshake pressures
		phase = 0;
		random_px = 0;
		while (random_px < RANDOM_ITEMS || phase < 4) begin
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 70; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase

			if (phase == 2) begin
				// Tallest frame with a masked width; the next phase cuts it short
				wdata = 12'h803;
				hdata = 12'hFFF;
			end else begin
				case ($urandom_range(9))
					0: wdata = 12'($urandom_range(2));
					1: wdata = 12'h800 | 12'($urandom_range(3, 12));
					default: wdata = 12'($urandom_range(3, 16));
				endcase
				if ($urandom_range(9) == 0)
					hdata = 12'($urandom_range(2));
				else
					hdata = 12'($urandom_range(3, 10));
			end
			configure(wdata, hdata);

			ew = (wdata[10:0] < 3) ? 3 : ((wdata[10:0] > 1024) ? 1024 : wdata[10:0]);
			eh = (hdata < 3) ? 3 : hdata;
			if (phase == 2)
				count = 150;
			else if ($urandom_range(9) < 7)
				count = ew * eh * $urandom_range(1, 2);
			else
				count = $urandom_range(1, 3 * ew);

			for (int n = 0; n < count; n++) begin
				case ($urandom_range(3))
					0, 1: px = 8'($urandom);
					2: px = $urandom_range(1) ? 8'd255 : 8'd0;
					default: px = 8'($urandom_range(126, 128));
				endcase
				send_pixel(px);
			end
			random_px += count;
			phase++;
		end

		// Drop valid, wait out the pending codes and the pipeline tail
		pixel_valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pixels over %0d frame settings, %0d codes checked",
			sb.pixels_seen, cfg_count, sb.codes_seen);
		$display("frames closed by a code: %0d; mismatches counted: %0d",
			sb.frames_seen, sb.errors);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hold a hard limit on run time
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d codes still pending", sb.pending());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
rtl/lbp_pkg.sv
rtl/lbp_scan.sv
rtl/lbp_line_buf.sv
rtl/lbp_window.sv
rtl/lbp_3x3_pixel_stream_top.sv
rtl/lbp_checker.sv
dv/lbp_3x3_pixel_stream_top_tb.sv
